// ===== hdl/mhs_pkg.sv =====
// Shared types and constants for the MinHash H3 sketch block.
`default_nettype none
package mhs_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int SEED_BITS = 32;
    localparam int FUNC_W    = 2;
    localparam int ROW_W     = 4;
    localparam int BIT_W     = 5;
    localparam int WORD_W    = 32;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMIT = 2'd2;

    typedef enum logic [1:0] {
        CMD_SEED,
        CMD_DATA,
        CMD_EMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ROW_W-1:0]   row;
        logic [BIT_W-1:0]   bit_index;
        logic [WORD_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage
`default_nettype wire

// ===== hdl/mhs_if.sv =====
// Valid/ready channel interfaces for sketch items and emitted row minima.
`default_nettype none
interface mhs_in_if;
    logic                       valid;
    logic                       ready;
    logic [mhs_pkg::FUNC_W-1:0] func;
    logic [mhs_pkg::ROW_W-1:0]  row;
    logic [mhs_pkg::BIT_W-1:0]  bit_index;
    logic [mhs_pkg::WORD_W-1:0] value;

    modport source (output valid, output func, output row, output bit_index,
                    output value, input ready);
    modport sink (input valid, input func, input row, input bit_index,
                  input value, output ready);
endinterface

interface mhs_out_if;
    logic                       valid;
    logic                       ready;
    logic [mhs_pkg::ROW_W-1:0]  out_row;
    logic [mhs_pkg::WORD_W-1:0] minimum;
    logic                       last;

    modport source (output valid, output out_row, output minimum, output last,
                    input ready);
    modport sink (input valid, input out_row, input minimum, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/minhash_sketch_h3.sv =====
// A data item reaches the row minima through the queue and then the hash register.
// The back end takes one seed write or data item per cycle while no emit is active;
// an emit holds it until one minimum per active row, min(ROWS, 16), is sent.
// An emit's first row minimum leaves via the queue, emit state and output register.
// Reset: queue empty, all row minima all ones; seed words undefined until written.
`default_nettype none
module minhash_sketch_h3 #(
    parameter int ROWS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mhs_in_if.sink    item,
    mhs_out_if.source result
);
    import mhs_pkg::*;

    localparam int ACT_ROWS = (ROWS > MAX_ROWS) ? MAX_ROWS : ROWS;

    q_head_t head;
    logic    pop;

    mhs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .head  (head),
        .pop   (pop)
    );

    mhs_back #(
        .ACT_ROWS (ACT_ROWS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire

// ===== hdl/mhs_front.sv =====
// Front end: decode items into commands and buffer them in a short queue.
`default_nettype none
module mhs_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    mhs_in_if.sink                item,
    output mhs_pkg::q_head_t      head,
    input  wire logic             pop
);
    import mhs_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              dec_cmd;
    logic              dec_keep;
    logic              xfer;
    logic              push;
    logic              do_pop;

    always_comb
    begin
        dec_cmd.row       = item.row;
        dec_cmd.bit_index = item.bit_index;
        dec_cmd.value     = item.value;
        dec_cmd.kind      = CMD_SEED;
        dec_keep          = 1'b1;
        case (item.func)
            FUNC_SEED: dec_cmd.kind = CMD_SEED;
            FUNC_DATA: dec_cmd.kind = CMD_DATA;
            FUNC_EMIT: dec_cmd.kind = CMD_EMIT;
            default:   dec_keep     = 1'b0;
        endcase
    end

    assign item.ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign xfer       = item.valid && item.ready;
    assign push       = xfer && dec_keep;
    assign do_pop     = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mhs_back.sv =====
// Back end: seed registers, H3 hash stage, row minima and emit sequencer.
`default_nettype none
module mhs_back #(
    parameter int ACT_ROWS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  mhs_pkg::q_head_t      head,
    output logic                  pop,
    mhs_out_if.source             result
);
    import mhs_pkg::*;

    localparam int RIDX_W = (ACT_ROWS > 1) ? $clog2(ACT_ROWS) : 1;

    logic [WORD_W-1:0] seed_reg [ACT_ROWS][SEED_BITS];
    logic [WORD_W-1:0] hash_reg [ACT_ROWS];
    logic [WORD_W-1:0] hash_next [ACT_ROWS];
    logic              hash_vld_reg, hash_vld_next;
    logic [WORD_W-1:0] min_reg [ACT_ROWS];
    logic              emit_act_reg, emit_act_next;
    logic [RIDX_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic              out_vld_reg, out_vld_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [WORD_W-1:0] out_min_reg;
    logic              out_last_reg;
    logic              out_load;
    logic              emit_step;
    logic              emit_end;
    logic              seed_we;

    assign pop       = head.valid && !emit_act_reg;
    assign seed_we   = pop && (head.cmd.kind == CMD_SEED);
    assign out_load  = !out_vld_reg || result.ready;
    assign emit_step = emit_act_reg && out_load;
    assign emit_end  = (emit_cnt_reg == RIDX_W'(ACT_ROWS - 1));

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < ACT_ROWS; r++)
        begin
            for (int b = 0; b < SEED_BITS; b++)
            begin
                if (seed_we && (head.cmd.row == ROW_W'(r))
                    && (head.cmd.bit_index == BIT_W'(b)))
                begin
                    seed_reg[r][b] <= head.cmd.value;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < ACT_ROWS; r++)
        begin
            hash_next[r] = '0;
            for (int b = 0; b < SEED_BITS; b++)
            begin
                if (head.cmd.value[b])
                begin
                    hash_next[r] = hash_next[r] ^ seed_reg[r][b];
                end
            end
        end
    end

    assign hash_vld_next = pop && (head.cmd.kind == CMD_DATA);

    always_ff @(posedge clk)
    begin
        if (hash_vld_next)
        begin
            hash_reg <= hash_next;
        end
        if (emit_step)
        begin
            out_row_reg  <= ROW_W'(emit_cnt_reg);
            out_min_reg  <= min_reg[emit_cnt_reg];
            out_last_reg <= emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ACT_ROWS; r++)
            begin
                min_reg[r] <= '1;
            end
        end
        else
        begin
            for (int r = 0; r < ACT_ROWS; r++)
            begin
                if (emit_step && (emit_cnt_reg == RIDX_W'(r)))
                begin
                    min_reg[r] <= '1;
                end
                else if (hash_vld_reg && (hash_reg[r] < min_reg[r]))
                begin
                    min_reg[r] <= hash_reg[r];
                end
            end
        end
    end

    always_comb
    begin
        emit_act_next = emit_act_reg;
        emit_cnt_next = emit_cnt_reg;
        if (pop && (head.cmd.kind == CMD_EMIT))
        begin
            emit_act_next = 1'b1;
            emit_cnt_next = '0;
        end
        else if (emit_step)
        begin
            if (emit_end)
            begin
                emit_act_next = 1'b0;
            end
            else
            begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
            end
        end
        if (emit_step)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_vld_reg <= 1'b0;
            emit_act_reg <= 1'b0;
            emit_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            hash_vld_reg <= hash_vld_next;
            emit_act_reg <= emit_act_next;
            emit_cnt_reg <= emit_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.out_row = out_row_reg;
    assign result.minimum = out_min_reg;
    assign result.last    = out_last_reg;

endmodule
`default_nettype wire

// ===== tb/minhash_sketch_h3_test.sv =====
// Self-checking testbench for the MinHash H3 sketch block: seed loads, item stream, emits.
`default_nettype none
module minhash_sketch_h3_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mhs_pkg::*;

    localparam int ROWS        = 16;
    localparam int ACTIVE_ROWS = (ROWS > MAX_ROWS) ? MAX_ROWS : ROWS;
    localparam int RAND_ITEMS  = 40;
    localparam int LOAD_STRIDE = 11;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 200000;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [WORD_W-1:0] minimum;
        logic              last;
    } row_min_t;

    logic clk;
    logic rst_n;

    mhs_in_if  in_ch ();
    mhs_out_if out_ch ();

    minhash_sketch_h3 #(
        .ROWS (ROWS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    logic [WORD_W-1:0] model_seeds [MAX_ROWS][SEED_BITS];
    logic [WORD_W-1:0] model_minima [MAX_ROWS];
    row_min_t          expected_minima [$];

    logic [SEED_BITS-1:0] seeds_sent [MAX_ROWS];

    int error_count    = 0;
    int cycle_count    = 0;
    int seed_writes    = 0;
    int data_items     = 0;
    int emit_count     = 0;
    int ignored_count  = 0;
    int minima_checked = 0;
    int burst_left     = 0;
    bit sender_gaps    = 1'b1;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("%0t: timeout with %0d row minima outstanding", $time,
                 expected_minima.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [WORD_W-1:0] h3_hash(input int r, input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < SEED_BITS; b++)
        begin
            if (v[b])
            begin
                acc ^= model_seeds[r][b];
            end
        end
        return acc;
    endfunction

    task automatic update_sketch(input logic [FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
                                 input logic [BIT_W-1:0] b, input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] h;
        row_min_t          emitted;
        case (f)
            FUNC_SEED:
            begin
                model_seeds[r][b] = v;
                seed_writes++;
            end
            FUNC_DATA:
            begin
                for (int i = 0; i < ACTIVE_ROWS; i++)
                begin
                    h = h3_hash(i, v);
                    if (h < model_minima[i])
                    begin
                        model_minima[i] = h;
                    end
                end
                data_items++;
            end
            FUNC_EMIT:
            begin
                for (int i = 0; i < ACTIVE_ROWS; i++)
                begin
                    emitted.row     = ROW_W'(i);
                    emitted.minimum = model_minima[i];
                    emitted.last    = (i == ACTIVE_ROWS - 1);
                    expected_minima.push_back(emitted);
                    model_minima[i] = '1;
                end
                emit_count++;
            end
            default:
            begin
                ignored_count++;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            update_sketch(in_ch.func, in_ch.row, in_ch.bit_index, in_ch.value);
        end
    end

    always @(posedge clk)
    begin : check_result
        row_min_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_minima.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer: expected none, %s %0d min %08h last %0b",
                         $time, "actual row", out_ch.out_row, out_ch.minimum,
                         out_ch.last);
            end
            else
            begin
                want = expected_minima.pop_front();
                minima_checked++;
                if (out_ch.out_row !== want.row)
                begin
                    error_count++;
                    $display("%0t: out_row expected %0d actual %0d",
                             $time, want.row, out_ch.out_row);
                end
                if (out_ch.minimum !== want.minimum)
                begin
                    error_count++;
                    $display("%0t: minimum of row %0d expected %08h actual %08h",
                             $time, want.row, want.minimum, out_ch.minimum);
                end
                if (out_ch.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last of row %0d expected %0b actual %0b",
                             $time, want.row, want.last, out_ch.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        case (cycle_count[8:7])
            2'd0: out_ch.ready <= 1'b1;
            2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ch.ready <= (cycle_count % 3 == 0);
            default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
                             input logic [BIT_W-1:0] b, input logic [WORD_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (sender_gaps && gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        if (f == FUNC_SEED)
        begin
            seeds_sent[r][b] = 1'b1;
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.row       <= r;
        in_ch.bit_index <= b;
        in_ch.value     <= v;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] usable_bits();
        logic [WORD_W-1:0] m;
        m = '1;
        for (int r = 0; r < ACTIVE_ROWS; r++)
        begin
            m &= seeds_sent[r];
        end
        return m;
    endfunction

    task automatic test_empty_emits();
        send_item(FUNC_EMIT, '0, '0, '0);
        send_item(FUNC_EMIT, '1, '1, '1);
    endtask

    task automatic test_zero_item();
        send_item(FUNC_DATA, '0, '0, 32'h0);
        send_item(FUNC_NONE, 4'hf, 5'h1f, 32'hffff_ffff);
        send_item(FUNC_DATA, '1, '1, 32'h0);
        send_item(FUNC_EMIT, '0, '0, '0);
        send_item(FUNC_EMIT, '0, '0, '0);
    endtask

    task automatic test_seed_extremes();
        send_item(FUNC_SEED, 4'd0, 5'd0, 32'h0000_0000);
        send_item(FUNC_SEED, 4'd15, 5'd31, 32'hffff_ffff);
        send_item(FUNC_SEED, 4'd9, 5'd17, 32'h5555_5555);
        send_item(FUNC_SEED, 4'd6, 5'd14, 32'haaaa_aaaa);
        send_item(FUNC_DATA, '0, '0, usable_bits() & 32'hffff_ffff);
        send_item(FUNC_EMIT, '0, '0, '0);
    endtask

    task automatic test_seed_load();
        logic [WORD_W-1:0] v;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int b = 0; b < SEED_BITS; b++)
            begin
                if (b == 0)
                    v = 32'hffff_ffff;
                else if (b == SEED_BITS - 1)
                    v = 32'h0;
                else
                    v = $urandom;
                if ((b % LOAD_STRIDE == 0) || (b == SEED_BITS - 1))
                    send_item(FUNC_SEED, ROW_W'(r), BIT_W'(b), v);
            end
        end
        send_item(FUNC_DATA, '0, '0, 32'h0000_0001);
        send_item(FUNC_EMIT, '0, '0, '0);
        send_item(FUNC_DATA, '0, '0, 32'hffff_ffff & usable_bits());
        send_item(FUNC_DATA, '0, '0, 32'h8000_0000);
        send_item(FUNC_DATA, '0, '0, 32'h8000_0000);
        send_item(FUNC_EMIT, '0, '0, '0);
    endtask

    task automatic test_random_stream();
        int                sent;
        int                kind;
        int                run;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] prev;
        sent = 0;
        prev = '0;
        while (sent < RAND_ITEMS)
        begin
            sender_gaps = (sent < RAND_ITEMS / 3) || (sent > 2 * RAND_ITEMS / 3);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                run = $urandom_range(1, 8);
                repeat (run)
                begin
                    case ($urandom_range(0, 5))
                        0: v = 32'h1 << $urandom_range(0, 31);
                        1: v = prev;
                        2: v = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
                        default: v = $urandom;
                    endcase
                    v &= usable_bits();
                    prev = v;
                    send_item(FUNC_DATA, ROW_W'($urandom), BIT_W'($urandom), v);
                    sent++;
                end
                send_item(FUNC_EMIT, ROW_W'($urandom), BIT_W'($urandom), $urandom);
                sent++;
            end
            else if (kind < 85)
            begin
                run = $urandom_range(1, 4);
                repeat (run)
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0;
                        1: v = 32'hffff_ffff;
                        default: v = $urandom;
                    endcase
                    send_item(FUNC_SEED, ROW_W'($urandom), BIT_W'($urandom), v);
                    sent++;
                end
            end
            else if (kind < 92)
            begin
                send_item(FUNC_NONE, ROW_W'($urandom), BIT_W'($urandom), $urandom);
            end
            else if (kind < 96)
            begin
                send_item(FUNC_EMIT, ROW_W'($urandom), BIT_W'($urandom), $urandom);
                sent++;
            end
            else
            begin
                send_item(FUNC_DATA, ROW_W'($urandom), BIT_W'($urandom),
                          $urandom & usable_bits());
                sent++;
            end
        end
        sender_gaps = 1'b1;
        send_item(FUNC_EMIT, '0, '0, '0);
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_NONE;
        in_ch.row       = '0;
        in_ch.bit_index = '0;
        in_ch.value     = '0;
        out_ch.ready    = 1'b0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            model_minima[r] = '1;
            seeds_sent[r]   = '0;
            for (int b = 0; b < SEED_BITS; b++)
            begin
                model_seeds[r][b] = '0;
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_emits();
        test_zero_item();
        test_seed_extremes();
        test_seed_load();
        test_random_stream();

        in_ch.valid <= 1'b0;
        while (expected_minima.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d seed writes, %0d data items, %0d emits, %0d unused codes.",
                 seed_writes, data_items, emit_count, ignored_count);
        $display("Compared %0d emitted row minima against the sketch prediction.",
                 minima_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
